### hw/rtl/sdi_pkg.sv
// ----------------------------------------------------------------------------
// sdi_pkg
// Types, codes and the command frame table shared by the SD SPI-mode
// start-up sequencer.
// ----------------------------------------------------------------------------
package sdi_pkg;

  // Input operation codes
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_XFER  = 2'd1,
    OP_TICK  = 2'd2
  } sdi_op_t;

  // Sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_WAKE   = 4'd1,
    PH_CMD0   = 4'd2,
    PH_CMD8   = 4'd3,
    PH_R7     = 4'd4,
    PH_CMD55  = 4'd5,
    PH_ACMD41 = 4'd6,
    PH_CMD58  = 4'd7,
    PH_OCR    = 4'd8,
    PH_CMD13  = 4'd9,
    PH_R2     = 4'd10
  } sdi_phase_t;

  // End-of-sequence outcome codes
  typedef enum logic [2:0] {
    OUT_V1       = 3'd0,
    OUT_V2       = 3'd1,
    OUT_NO_CARD  = 3'd2,
    OUT_VOLTAGE  = 3'd3,
    OUT_TIMEOUT  = 3'd4
  } sdi_outcome_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_V2_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_V1_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_POLL_LIMIT = 2'd2;

  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned MS_W       = 10;

  // Byte position of the first response poll within a command frame
  localparam logic [3:0]      POLL_START  = 4'd7;
  localparam logic [MS_W-1:0] ELAPSED_MAX = 10'd1023;

  localparam logic [7:0] FILL_BYTE = 8'hFF;
  localparam logic [7:0] R1_IDLE   = 8'h01;
  localparam logic [7:0] R1_READY  = 8'h00;
  localparam logic [7:0] ECHO_VHS  = 8'h01;
  localparam logic [7:0] ECHO_PAT  = 8'hAA;

  typedef struct packed {
    logic [MS_W-1:0] v2_timeout;
    logic [MS_W-1:0] v1_timeout;
    logic [3:0]      poll_limit;
  } sdi_cfg_t;

  typedef struct packed {
    logic       valid;
    sdi_op_t    op;
    logic [7:0] rx;
  } sdi_item_t;

  // Byte k of the command frame for a phase: leading filler, command,
  // argument MSB first, CRC
  function automatic logic [7:0] frame_byte(sdi_phase_t ph, logic [3:0] k, logic v2);
    logic [5:0]  idx;
    logic [31:0] arg;
    logic [7:0]  crc;
    logic [7:0]  b;
    idx = 6'd13;
    arg = 32'h0;
    crc = 8'h01;
    case (ph)
      PH_CMD0: begin
        idx = 6'd0;
        crc = 8'h95;
      end
      PH_CMD8: begin
        idx = 6'd8;
        arg = 32'h0000_01AA;
        crc = 8'h87;
      end
      PH_CMD55: idx = 6'd55;
      PH_ACMD41: begin
        idx = 6'd41;
        arg = v2 ? 32'h4000_0000 : 32'h0;
      end
      PH_CMD58: idx = 6'd58;
      default: idx = 6'd13;
    endcase
    case (k)
      4'd0:    b = FILL_BYTE;
      4'd1:    b = 8'h40 | {2'b00, idx};
      4'd2:    b = arg[31:24];
      4'd3:    b = arg[23:16];
      4'd4:    b = arg[15:8];
      4'd5:    b = arg[7:0];
      default: b = crc;
    endcase
    return b;
  endfunction

endpackage

### hw/rtl/sdi_if.sv
// ----------------------------------------------------------------------------
// sdi_if
// Valid/ready channels of the sequencer: event words in, result words out.
// ----------------------------------------------------------------------------
interface sdi_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] rx_byte;

  modport source (output valid, operation, rx_byte, input ready);
  modport sink   (input valid, operation, rx_byte, output ready);
endinterface

interface sdi_out_if;
  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       chip_select;
  logic       done_res;
  logic [2:0] outcome;
  logic [7:0] last_response;

  modport source (output valid, tx_valid, tx_byte, chip_select, done_res, outcome,
                  last_response, input ready);
  modport sink   (input valid, tx_valid, tx_byte, chip_select, done_res, outcome,
                  last_response, output ready);
endinterface

### hw/rtl/sdi_cfg.sv
// ----------------------------------------------------------------------------
// sdi_cfg
// Configuration registers: ready timeouts and response poll limit.
// ----------------------------------------------------------------------------
module sdi_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [1:0]                       cfg_index,
  input  logic [sdi_pkg::CFG_DATA_W-1:0]   cfg_data,
  output sdi_pkg::sdi_cfg_t                cfg
);
  import sdi_pkg::*;

  // Write the addressed register; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.v2_timeout <= 10'd100;
      cfg.v1_timeout <= 10'd1000;
      cfg.poll_limit <= 4'd10;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_V2_TIMEOUT: cfg.v2_timeout <= cfg_data[MS_W-1:0];
        CFG_V1_TIMEOUT: cfg.v1_timeout <= cfg_data[MS_W-1:0];
        CFG_POLL_LIMIT: cfg.poll_limit <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

endmodule

### hw/rtl/sdi_in_reg.sv
// ----------------------------------------------------------------------------
// sdi_in_reg
// Input register: holds one event word until the sequencer takes it.
// ----------------------------------------------------------------------------
module sdi_in_reg (
  input  logic               clk,
  input  logic               rst,
  sdi_in_if.sink             in_chan,
  input  logic               take,
  output sdi_pkg::sdi_item_t item
);
  import sdi_pkg::*;

  // Accept when empty or when the held word leaves this cycle
  assign in_chan.ready = !item.valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
    end else if (in_chan.ready) begin
      item.valid <= in_chan.valid;
    end
    if (in_chan.valid && in_chan.ready) begin
      item.op <= sdi_op_t'(in_chan.operation);
      item.rx <= in_chan.rx_byte;
    end
  end

endmodule

### hw/rtl/sdi_seq.sv
// ----------------------------------------------------------------------------
// sdi_seq
// Sequencer state and result register: one event word per cycle while the result register is free or drains.
// ----------------------------------------------------------------------------
module sdi_seq #(
  parameter int unsigned WAKE_BYTES = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  sdi_pkg::sdi_item_t item,
  input  sdi_pkg::sdi_cfg_t  cfg,
  output logic               take,
  sdi_out_if.source          out_chan
);
  import sdi_pkg::*;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_EMIT,
    ACT_START,
    ACT_TRAIL,
    ACT_LOOP,
    ACT_FINISH
  } act_t;

  sdi_phase_t      phase, phase_next;
  logic [3:0]      byte_count, byte_count_next;
  logic [3:0]      polls_left, polls_left_next;
  logic [MS_W-1:0] elapsed_ms, elapsed_ms_next;
  logic            card_is_v2, card_is_v2_next;
  logic [7:0]      echo_bytes [2];
  logic [7:0]      echo_next [2];
  logic [7:0]      response_byte, response_byte_next;

  act_t         act;
  sdi_phase_t   act_ph;
  logic [7:0]   act_tx;
  logic         act_cs;
  sdi_outcome_t act_code;
  logic [3:0]   bc_inc;
  logic [3:0]   trail_len;
  logic [MS_W-1:0] limit;
  logic         res_valid;
  logic         res_tx_valid;
  logic [7:0]   res_tx;
  logic         res_cs;
  logic         res_done;
  sdi_outcome_t res_outcome;

  // Take the held word when the result register is free or drains
  assign take = item.valid && (!out_chan.valid || out_chan.ready);

  always_comb begin
    phase_next         = phase;
    byte_count_next    = byte_count;
    polls_left_next    = polls_left;
    elapsed_ms_next    = elapsed_ms;
    card_is_v2_next    = card_is_v2;
    echo_next[0]       = echo_bytes[0];
    echo_next[1]       = echo_bytes[1];
    response_byte_next = response_byte;
    act      = ACT_NONE;
    act_ph   = PH_IDLE;
    act_tx   = FILL_BYTE;
    act_cs   = 1'b1;
    act_code = OUT_V1;
    bc_inc    = byte_count + 4'd1;
    trail_len = (phase == PH_R2) ? 4'd1 : 4'd4;

    // Decide the action for this word
    if (take) begin
      case (item.op)
        OP_START: begin
          card_is_v2_next    = 1'b0;
          polls_left_next    = 4'd0;
          byte_count_next    = 4'd0;
          response_byte_next = FILL_BYTE;
          phase_next         = PH_WAKE;
          elapsed_ms_next    = 10'd1;
          act    = ACT_EMIT;
          act_cs = 1'b0;
        end
        OP_TICK: begin
          if ((phase == PH_CMD55 || phase == PH_ACMD41) && elapsed_ms < ELAPSED_MAX) begin
            elapsed_ms_next = elapsed_ms + 10'd1;
          end
        end
        OP_XFER: begin
          case (phase)
            PH_IDLE: act = ACT_NONE;
            PH_WAKE: begin
              if (elapsed_ms < MS_W'(WAKE_BYTES)) begin
                elapsed_ms_next = elapsed_ms + 10'd1;
                act    = ACT_EMIT;
                act_cs = 1'b0;
              end else begin
                elapsed_ms_next = '0;
                act    = ACT_START;
                act_ph = PH_CMD0;
              end
            end
            PH_R7, PH_OCR, PH_R2: begin
              // Trailing response bytes; capture the CMD8 echo
              if (phase == PH_R7 && byte_count == 4'd2) echo_next[0] = item.rx;
              if (phase == PH_R7 && byte_count == 4'd3) echo_next[1] = item.rx;
              byte_count_next = bc_inc;
              if (bc_inc < trail_len) begin
                act = ACT_EMIT;
              end else if (phase == PH_R7) begin
                if (echo_next[0] != ECHO_VHS || echo_next[1] != ECHO_PAT) begin
                  act      = ACT_FINISH;
                  act_code = OUT_VOLTAGE;
                end else begin
                  card_is_v2_next = 1'b1;
                  elapsed_ms_next = '0;
                  act = ACT_LOOP;
                end
              end else if (phase == PH_OCR) begin
                act    = ACT_START;
                act_ph = PH_CMD13;
              end else begin
                act      = ACT_FINISH;
                act_code = card_is_v2 ? OUT_V2 : OUT_V1;
              end
            end
            default: begin
              if (byte_count < POLL_START) begin
                // Frame bytes
                byte_count_next = bc_inc;
                act    = ACT_EMIT;
                act_tx = frame_byte(phase, byte_count, card_is_v2);
              end else if (byte_count == POLL_START) begin
                byte_count_next = bc_inc;
                polls_left_next = (cfg.poll_limit != 4'd0) ? cfg.poll_limit : 4'd1;
                act = ACT_EMIT;
              end else begin
                // Poll for an R1 response
                response_byte_next = item.rx;
                if (item.rx[7] && polls_left > 4'd1) begin
                  polls_left_next = polls_left - 4'd1;
                  act = ACT_EMIT;
                end else begin
                  polls_left_next = 4'd0;
                  case (phase)
                    PH_CMD0: begin
                      if (item.rx == R1_IDLE) begin
                        act    = ACT_START;
                        act_ph = PH_CMD8;
                      end else begin
                        act      = ACT_FINISH;
                        act_code = OUT_NO_CARD;
                      end
                    end
                    PH_CMD8: begin
                      if (item.rx == R1_IDLE) begin
                        act    = ACT_TRAIL;
                        act_ph = PH_R7;
                      end else begin
                        card_is_v2_next = 1'b0;
                        elapsed_ms_next = '0;
                        act = ACT_LOOP;
                      end
                    end
                    PH_CMD55: begin
                      if (item.rx > R1_IDLE) begin
                        act = ACT_LOOP;
                      end else begin
                        act    = ACT_START;
                        act_ph = PH_ACMD41;
                      end
                    end
                    PH_ACMD41: begin
                      if (item.rx == R1_READY) begin
                        act    = ACT_START;
                        act_ph = PH_CMD58;
                      end else begin
                        act = ACT_LOOP;
                      end
                    end
                    PH_CMD58: begin
                      if (item.rx == R1_READY) begin
                        act    = ACT_TRAIL;
                        act_ph = PH_OCR;
                      end else begin
                        act    = ACT_START;
                        act_ph = PH_CMD13;
                      end
                    end
                    default: begin
                      if (item.rx == R1_READY) begin
                        act    = ACT_TRAIL;
                        act_ph = PH_R2;
                      end else begin
                        act      = ACT_FINISH;
                        act_code = card_is_v2 ? OUT_V2 : OUT_V1;
                      end
                    end
                  endcase
                end
              end
            end
          endcase
        end
        default: act = ACT_NONE;
      endcase
    end

    // Resolve a ready-loop pass: timeout check, then CMD55
    limit = card_is_v2_next ? cfg.v2_timeout : cfg.v1_timeout;
    if (act == ACT_LOOP) begin
      if (elapsed_ms_next >= limit) begin
        act      = ACT_FINISH;
        act_code = OUT_TIMEOUT;
      end else begin
        act    = ACT_START;
        act_ph = PH_CMD55;
      end
    end

    // Apply the action and form the result word
    res_valid    = 1'b0;
    res_tx_valid = 1'b1;
    res_tx       = act_tx;
    res_cs       = act_cs;
    res_done     = 1'b0;
    res_outcome  = OUT_V1;
    case (act)
      ACT_EMIT: res_valid = 1'b1;
      ACT_START: begin
        phase_next      = act_ph;
        byte_count_next = 4'd1;
        res_valid = 1'b1;
        res_tx    = FILL_BYTE;
        res_cs    = 1'b1;
      end
      ACT_TRAIL: begin
        phase_next      = act_ph;
        byte_count_next = 4'd0;
        res_valid = 1'b1;
        res_tx    = FILL_BYTE;
        res_cs    = 1'b1;
      end
      ACT_FINISH: begin
        phase_next      = PH_IDLE;
        byte_count_next = 4'd0;
        polls_left_next = 4'd0;
        res_valid    = 1'b1;
        res_tx_valid = 1'b0;
        res_tx       = 8'h00;
        res_cs       = 1'b0;
        res_done     = 1'b1;
        res_outcome  = act_code;
      end
      default: res_valid = 1'b0;
    endcase
  end

  // Hold state; load the result register, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      byte_count     <= 4'd0;
      polls_left     <= 4'd0;
      elapsed_ms     <= '0;
      card_is_v2     <= 1'b0;
      response_byte  <= FILL_BYTE;
      out_chan.valid <= 1'b0;
    end else begin
      phase         <= phase_next;
      byte_count    <= byte_count_next;
      polls_left    <= polls_left_next;
      elapsed_ms    <= elapsed_ms_next;
      card_is_v2    <= card_is_v2_next;
      response_byte <= response_byte_next;
      if (take && res_valid) begin
        out_chan.valid <= 1'b1;
      end else if (out_chan.ready) begin
        out_chan.valid <= 1'b0;
      end
    end
    echo_bytes[0] <= echo_next[0];
    echo_bytes[1] <= echo_next[1];
    if (take && res_valid) begin
      out_chan.tx_valid      <= res_tx_valid;
      out_chan.tx_byte       <= res_tx;
      out_chan.chip_select   <= res_cs;
      out_chan.done_res      <= res_done;
      out_chan.outcome       <= res_outcome;
      out_chan.last_response <= response_byte_next;
    end
  end

endmodule

### hw/rtl/sd_spi_init_sequencer_core.sv
// ----------------------------------------------------------------------------
// sd_spi_init_sequencer_core
// SD card SPI-mode start-up sequencer: wake bytes, CMD0, CMD8, the
// CMD55/ACMD41 ready loop, CMD58 and CMD13, one byte exchange at a time.
// ----------------------------------------------------------------------------
// Feed one event word per SPI byte exchange, per millisecond tick, or to
// start. Each word passes an input register and is then handled by the
// sequencer, whose answer (the next byte to shift out, or the final
// outcome with chip select dropped) lands in a result register. A new
// word is accepted every cycle as long as the result side keeps draining.
// Ticks and exchange words that need no answer produce no result word.
module sd_spi_init_sequencer_core #(
  parameter int unsigned WAKE_BYTES = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [1:0]                     cfg_index,
  input  logic [sdi_pkg::CFG_DATA_W-1:0] cfg_data,
  sdi_in_if.sink                         in_chan,
  sdi_out_if.source                      out_chan
);
  import sdi_pkg::*;

  sdi_cfg_t  cfg;
  sdi_item_t item;
  logic      take;

  sdi_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sdi_in_reg u_in_reg (
    .clk     (clk),
    .rst     (rst),
    .in_chan (in_chan),
    .take    (take),
    .item    (item)
  );

  sdi_seq #(
    .WAKE_BYTES (WAKE_BYTES)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .cfg      (cfg),
    .take     (take),
    .out_chan (out_chan)
  );

endmodule
